// ===== hw/rtl/intel_hex_record_parser_macros.svh =====
// Assertion helpers for the record parser.
`ifndef INTEL_HEX_RECORD_PARSER_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define IHEX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define IHEX_NEVER(lbl, clk, rst_n, cond, msg) \
  `IHEX_ASSERT(lbl, clk, rst_n, !(cond), msg)

`else

`define IHEX_ASSERT(lbl, clk, rst_n, prop, msg)

`define IHEX_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hw/rtl/ihex_pkg.sv =====
`timescale 1ns / 1ps
package ihex_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // character class of one input transfer
  typedef enum logic [2:0] {
    CLS_END   = 3'd0,
    CLS_COLON = 3'd1,
    CLS_LF    = 3'd2,
    CLS_CR    = 3'd3,
    CLS_BLANK = 3'd4,
    CLS_HEX   = 3'd5,
    CLS_OTHER = 3'd6
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] nib;
  } tok_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_END   = 2'd1,
    STAT_BAD   = 2'd2,
    STAT_CKSUM = 2'd3
  } status_t;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] EOF_TYPE_RST = 8'h01;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/ihex_front.sv =====
`timescale 1ns / 1ps
module ihex_front
  import ihex_pkg::*;
(
  input  logic    push,
  input  logic [7:0] in_ch,
  input  logic    in_at_end,
  input  q_stat_t q_stat,
  output logic    full,
  output logic    q_wr,
  output tok_t    q_tok
);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  assign full = q_stat.full;
  assign q_wr = push && !q_stat.full;

  always_comb begin
    q_tok.nib = 4'd0;
    q_tok.cls = CLS_OTHER;
    if (in_at_end) begin
      q_tok.cls = CLS_END;
    end else begin
      case (in_ch) inside
        CH_COLON: q_tok.cls = CLS_COLON;
        CH_LF: q_tok.cls = CLS_LF;
        CH_CR: q_tok.cls = CLS_CR;
        CH_TAB, CH_SPACE: q_tok.cls = CLS_BLANK;
        [CH_0:CH_9]: begin
          q_tok.cls = CLS_HEX;
          q_tok.nib = in_ch[3:0];
        end
        [CH_UA:CH_UF], [CH_LA:CH_LF_HEX]: begin
          q_tok.cls = CLS_HEX;
          q_tok.nib = in_ch[3:0] + 4'd9;
        end
        default: q_tok.cls = CLS_OTHER;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ihex_queue.sv =====
`timescale 1ns / 1ps
`include "intel_hex_record_parser_macros.svh"
module ihex_queue
  import ihex_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr,
  input  tok_t    wr_tok,
  input  logic    rd,
  output tok_t    rd_tok,
  output q_stat_t q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tok_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_FULL);
  assign q_stat.empty = (count_r == '0);
  assign rd_tok       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr && !rd) begin
      count_nxt = count_r + 1'b1;
    end else if (rd && !wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr_r] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `IHEX_ASSERT(a_cnt_range, clk, rst_n, count_r <= CNT_FULL, "queue count beyond depth")
  `IHEX_ASSERT(a_empty_ptrs, clk, rst_n, (count_r == '0) |-> (wr_ptr_r == rd_ptr_r),
               "empty queue with split pointers")

endmodule

// ===== hw/rtl/ihex_back.sv =====
`timescale 1ns / 1ps
`include "intel_hex_record_parser_macros.svh"
module ihex_back
  import ihex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tok_valid,
  input  tok_t        tok,
  input  logic [7:0]  eof_type,
  input  logic        pop,
  output logic        tok_pop,
  output logic        empty,
  output logic        out_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_offset,
  output logic [15:0] out_rec_addr,
  output logic [7:0]  out_rec_type,
  output logic [7:0]  out_rec_len,
  output logic [1:0]  out_status
);

  typedef enum logic [7:0] {
    PH_HUNT = 8'b0000_0001,
    PH_LEN  = 8'b0000_0010,
    PH_AHI  = 8'b0000_0100,
    PH_ALO  = 8'b0000_1000,
    PH_TYPE = 8'b0001_0000,
    PH_DATA = 8'b0010_0000,
    PH_SUM  = 8'b0100_0000,
    PH_TAIL = 8'b1000_0000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hi_nib_r, hi_nib_nxt;
  logic        second_r, second_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic        out_valid_r;

  logic        adv;
  logic        emit;
  logic        fin;
  status_t     fin_stat;
  logic [7:0]  byte_val;
  logic [7:0]  sum_add;
  logic [7:0]  seen_inc;

  logic        res_kind;
  logic [7:0]  res_data;
  logic [7:0]  res_offset;
  logic [15:0] res_addr;
  logic [7:0]  res_type;
  logic [7:0]  res_len;
  status_t     res_stat;

  assign adv      = !out_valid_r || pop;
  assign tok_pop  = tok_valid && adv;
  assign empty    = !out_valid_r;
  assign byte_val = {hi_nib_r, tok.nib};
  assign sum_add  = sum_r + byte_val;
  assign seen_inc = seen_r + 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    hi_nib_nxt = hi_nib_r;
    second_nxt = second_r;
    sum_nxt    = sum_r;
    len_nxt    = len_r;
    addr_nxt   = addr_r;
    type_nxt   = type_r;
    seen_nxt   = seen_r;
    emit       = 1'b0;
    fin        = 1'b0;
    fin_stat   = STAT_OK;
    res_kind   = KIND_DATA;
    res_data   = 8'd0;
    res_offset = 8'd0;
    res_addr   = addr_r;
    res_type   = type_r;
    res_len    = len_r;
    res_stat   = STAT_OK;

    case (phase_r)
      PH_TAIL: begin
        case (tok.cls)
          CLS_END: begin
            fin      = 1'b1;
            fin_stat = (type_r == eof_type) ? STAT_OK : STAT_END;
          end
          CLS_LF: begin
            fin      = 1'b1;
            fin_stat = STAT_OK;
          end
          CLS_CR, CLS_BLANK: ;
          default: begin
            fin      = 1'b1;
            fin_stat = STAT_BAD;
          end
        endcase
      end
      PH_LEN, PH_AHI, PH_ALO, PH_TYPE, PH_DATA, PH_SUM: begin
        if (tok.cls == CLS_END) begin
          fin      = 1'b1;
          fin_stat = STAT_END;
        end else if (tok.cls != CLS_HEX) begin
          fin      = 1'b1;
          fin_stat = STAT_BAD;
        end else if (!second_r) begin
          hi_nib_nxt = tok.nib;
          second_nxt = 1'b1;
        end else begin
          second_nxt = 1'b0;
          sum_nxt    = sum_add;
          case (phase_r)
            PH_LEN: begin
              len_nxt   = byte_val;
              phase_nxt = PH_AHI;
            end
            PH_AHI: begin
              addr_nxt  = {byte_val, 8'd0};
              phase_nxt = PH_ALO;
            end
            PH_ALO: begin
              addr_nxt  = {addr_r[15:8], byte_val};
              phase_nxt = PH_TYPE;
            end
            PH_TYPE: begin
              type_nxt  = byte_val;
              phase_nxt = (len_r != 8'd0) ? PH_DATA : PH_SUM;
            end
            PH_DATA: begin
              emit       = 1'b1;
              res_data   = byte_val;
              res_offset = seen_r;
              seen_nxt   = seen_inc;
              if (seen_inc == len_r) begin
                phase_nxt = PH_SUM;
              end
            end
            default: begin
              if (sum_add != 8'd0) begin
                fin      = 1'b1;
                fin_stat = STAT_CKSUM;
              end else begin
                phase_nxt = PH_TAIL;
              end
            end
          endcase
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        case (tok.cls)
          CLS_END: begin
            fin      = 1'b1;
            fin_stat = STAT_END;
          end
          CLS_COLON: begin
            hi_nib_nxt = 4'd0;
            second_nxt = 1'b0;
            sum_nxt    = 8'd0;
            len_nxt    = 8'd0;
            addr_nxt   = 16'd0;
            type_nxt   = 8'd0;
            seen_nxt   = 8'd0;
            phase_nxt  = PH_LEN;
          end
          CLS_CR, CLS_LF: ;
          default: begin
            fin      = 1'b1;
            fin_stat = STAT_BAD;
          end
        endcase
      end
    endcase

    if (fin) begin
      emit       = 1'b1;
      res_kind   = KIND_STATUS;
      res_data   = 8'd0;
      res_offset = 8'd0;
      res_stat   = fin_stat;
      hi_nib_nxt = 4'd0;
      second_nxt = 1'b0;
      sum_nxt    = 8'd0;
      len_nxt    = 8'd0;
      addr_nxt   = 16'd0;
      type_nxt   = 8'd0;
      seen_nxt   = 8'd0;
      phase_nxt  = PH_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      hi_nib_r    <= 4'd0;
      second_r    <= 1'b0;
      sum_r       <= 8'd0;
      len_r       <= 8'd0;
      addr_r      <= 16'd0;
      type_r      <= 8'd0;
      seen_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (tok_pop) begin
        phase_r  <= phase_nxt;
        hi_nib_r <= hi_nib_nxt;
        second_r <= second_nxt;
        sum_r    <= sum_nxt;
        len_r    <= len_nxt;
        addr_r   <= addr_nxt;
        type_r   <= type_nxt;
        seen_r   <= seen_nxt;
      end
      if (adv) begin
        out_valid_r <= tok_pop && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && emit) begin
      out_kind      <= res_kind;
      out_data_byte <= res_data;
      out_offset    <= res_offset;
      out_rec_addr  <= res_addr;
      out_rec_type  <= res_type;
      out_rec_len   <= res_len;
      out_status    <= res_stat;
    end
  end

  `IHEX_ASSERT(a_data_count, clk, rst_n, (phase_r == PH_DATA) |-> (seen_r < len_r),
               "data phase with all bytes already seen")
  `IHEX_NEVER(a_hunt_clear, clk, rst_n,
              (phase_r == PH_HUNT) && (second_r || (sum_r != 8'd0) || (seen_r != 8'd0)),
              "record state not cleared while hunting")
  `IHEX_ASSERT(a_data_ok, clk, rst_n,
               (out_valid_r && (out_kind == KIND_DATA)) |-> (out_status == STAT_OK),
               "data result carries a status")

endmodule

// ===== hw/rtl/intel_hex_record_parser.sv =====
// Intel HEX record parser.
// Input: one text character per transfer on in_ch, or an end-of-file marker
// with in_at_end high; a transfer happens when push is high and full is low.
// Results: the oldest result sits on the out_ ports while empty is low and
// leaves when pop is high. out_kind 0 is a data byte with its offset; 1 ends a
// record with out_status (ok, unexpected end, bad line, bad checksum).
// cfg_we/cfg_wdata set the end-of-file record type (1 after reset); write it
// only while no characters are in flight.
// A character is written into a small token queue; the parser reads it from
// there and registers any result. Throughput: one character per cycle while
// results are taken, set by the parser state update.
// A stalled result receiver holds the output register; characters keep
// filling the queue (QUEUE_DEPTH entries) until full rises.
// Reset (rst_n low, synchronous) empties the queue and output, and the
// parser hunts for ':'.
`timescale 1ns / 1ps
module intel_hex_record_parser
  import ihex_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_ch,
  input  logic        in_at_end,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_offset,
  output logic [15:0] out_rec_addr,
  output logic [7:0]  out_rec_type,
  output logic [7:0]  out_rec_len,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  q_stat_t    q_stat;
  logic       q_wr;
  tok_t       q_wr_tok;
  logic       q_rd;
  tok_t       q_rd_tok;
  logic [7:0] eof_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eof_type_r <= EOF_TYPE_RST;
    end else if (cfg_we) begin
      eof_type_r <= cfg_wdata;
    end
  end

  ihex_front u_front (
    .push      (push),
    .in_ch     (in_ch),
    .in_at_end (in_at_end),
    .q_stat    (q_stat),
    .full      (full),
    .q_wr      (q_wr),
    .q_tok     (q_wr_tok)
  );

  ihex_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wr_tok (q_wr_tok),
    .rd     (q_rd),
    .rd_tok (q_rd_tok),
    .q_stat (q_stat)
  );

  ihex_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .tok_valid     (!q_stat.empty),
    .tok           (q_rd_tok),
    .eof_type      (eof_type_r),
    .pop           (pop),
    .tok_pop       (q_rd),
    .empty         (empty),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_offset    (out_offset),
    .out_rec_addr  (out_rec_addr),
    .out_rec_type  (out_rec_type),
    .out_rec_len   (out_rec_len),
    .out_status    (out_status)
  );

endmodule

// ===== verif/tb_intel_hex_record_parser.sv =====
`timescale 1ns / 1ps
module tb_intel_hex_record_parser;
  import ihex_pkg::*;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEM_GOAL     = 1600;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE, PH_DATA, PH_SUM, PH_TAIL
  } parse_phase_t;

  typedef enum int {
    FLAW_NONE, FLAW_CKSUM, FLAW_NONHEX, FLAW_END_EARLY, FLAW_TAIL_CHAR, FLAW_END_AFTER_SUM
  } rec_flaw_t;

  typedef struct {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  offset;
    logic [15:0] addr;
    logic [7:0]  rtype;
    logic [7:0]  len;
    status_t     status;
  } hex_result_t;

  // 0..15 for a hex digit, 16 otherwise
  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return c - CH_ZERO;
    if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) return c - CH_UPPER_A + 10;
    if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) return c - CH_LOWER_A + 10;
    return 16;
  endfunction

  class ihex_result_tracker;
    logic [7:0]   eof_type;
    parse_phase_t phase;
    logic [3:0]   hi_nib;
    logic         second;
    logic [7:0]   sum;
    logic [7:0]   len;
    logic [15:0]  addr;
    logic [7:0]   rtype;
    logic [7:0]   count;
    hex_result_t  pending_results[$];
    int           errors;

    function new();
      eof_type = EOF_TYPE_RST;
      phase = PH_HUNT;
      errors = 0;
      clear_record();
    endfunction

    function void clear_record();
      hi_nib = '0;
      second = 1'b0;
      sum = '0;
      len = '0;
      addr = '0;
      rtype = '0;
      count = '0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void end_record(input status_t st);
      hex_result_t r;
      r.kind = KIND_STATUS;
      r.data_byte = '0;
      r.offset = '0;
      r.addr = addr;
      r.rtype = rtype;
      r.len = len;
      r.status = st;
      pending_results.push_back(r);
      clear_record();
      phase = PH_HUNT;
    endfunction

    function void note_char(input logic [7:0] c, input logic at_end);
      int v;
      logic [7:0] b;
      hex_result_t r;
      if (phase == PH_TAIL) begin
        if (at_end) end_record(rtype == eof_type ? STAT_OK : STAT_END);
        else if (c == CH_LF) end_record(STAT_OK);
        else if (!(c == CH_TAB || c == CH_CR || c == CH_SPACE)) end_record(STAT_BAD);
        return;
      end
      if (phase == PH_HUNT) begin
        if (at_end) end_record(STAT_END);
        else if (c == CH_COLON) begin
          clear_record();
          phase = PH_LEN;
        end else if (c != CH_CR && c != CH_LF) end_record(STAT_BAD);
        return;
      end
      if (at_end) begin
        end_record(STAT_END);
        return;
      end
      v = hex_digit_value(c);
      if (v > 15) begin
        end_record(STAT_BAD);
        return;
      end
      if (!second) begin
        hi_nib = v[3:0];
        second = 1'b1;
        return;
      end
      second = 1'b0;
      b = {hi_nib, v[3:0]};
      sum = sum + b;
      case (phase)
        PH_LEN: begin
          len = b;
          phase = PH_ADDR_HI;
        end
        PH_ADDR_HI: begin
          addr = {b, 8'h00};
          phase = PH_ADDR_LO;
        end
        PH_ADDR_LO: begin
          addr[7:0] = b;
          phase = PH_TYPE;
        end
        PH_TYPE: begin
          rtype = b;
          phase = (len != 0) ? PH_DATA : PH_SUM;
        end
        PH_DATA: begin
          r.kind = KIND_DATA;
          r.data_byte = b;
          r.offset = count;
          r.addr = addr;
          r.rtype = rtype;
          r.len = len;
          r.status = STAT_OK;
          pending_results.push_back(r);
          count = count + 8'd1;
          if (count == len) phase = PH_SUM;
        end
        default: begin
          if (sum != 0) end_record(STAT_CKSUM);
          else phase = PH_TAIL;
        end
      endcase
    endfunction

    function void compare_field(input string name, input logic [15:0] exp_v,
                                input logic [15:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(input hex_result_t got);
      hex_result_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                 $time, got.kind, got.status);
        return;
      end
      exp_r = pending_results.pop_front();
      compare_field("kind", exp_r.kind, got.kind);
      compare_field("data_byte", exp_r.data_byte, got.data_byte);
      compare_field("offset", exp_r.offset, got.offset);
      compare_field("rec_addr", exp_r.addr, got.addr);
      compare_field("rec_type", exp_r.rtype, got.rtype);
      compare_field("rec_len", exp_r.len, got.len);
      compare_field("status", exp_r.status, got.status);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_ch;
  logic        in_at_end;
  logic        empty;
  logic        pop;
  logic        out_kind;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_offset;
  logic [15:0] out_rec_addr;
  logic [7:0]  out_rec_type;
  logic [7:0]  out_rec_len;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;

  ihex_result_tracker trk;
  int n_items;
  int hold_left;
  bit steady;

  intel_hex_record_parser dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_ch        (in_ch),
    .in_at_end    (in_at_end),
    .empty        (empty),
    .pop          (pop),
    .out_kind     (out_kind),
    .out_data_byte(out_data_byte),
    .out_offset   (out_offset),
    .out_rec_addr (out_rec_addr),
    .out_rec_type (out_rec_type),
    .out_rec_len  (out_rec_len),
    .out_status   (out_status),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // one transfer on the character side
  task automatic send_item(input logic [7:0] c, input logic at_end);
    while (!steady && $urandom_range(0, 99) < 35) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_ch <= c;
    in_at_end <= at_end;
    do @(posedge clk); while (full);
    trk.note_char(c, at_end);
    n_items++;
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return CH_ZERO + n;
    return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + n - 8'd10;
  endfunction

  // sender stops, results drain, then the register is written
  task automatic write_eof_type(input logic [7:0] value);
    push <= 1'b0;
    @(posedge clk);
    while (trk.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    trk.eof_type = value;
  endtask

  task automatic send_record(input logic [7:0] len, input logic [15:0] addr,
                             input logic [7:0] rtype, input rec_flaw_t flaw);
    logic [7:0] bytes_q[$];
    logic [7:0] line[$];
    logic [7:0] sum;
    logic [7:0] c;
    int cut;
    sum = '0;
    bytes_q.push_back(len);
    bytes_q.push_back(addr[15:8]);
    bytes_q.push_back(addr[7:0]);
    bytes_q.push_back(rtype);
    for (int i = 0; i < len; i++) bytes_q.push_back(8'($urandom_range(0, 255)));
    foreach (bytes_q[i]) sum = sum + bytes_q[i];
    sum = -sum;
    if (flaw == FLAW_CKSUM) sum = sum ^ 8'($urandom_range(1, 255));
    bytes_q.push_back(sum);
    line.push_back(CH_COLON);
    foreach (bytes_q[i]) begin
      line.push_back(hex_char(bytes_q[i][7:4]));
      line.push_back(hex_char(bytes_q[i][3:0]));
    end
    repeat ($urandom_range(0, 2)) send_item($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
    if (flaw == FLAW_NONHEX || flaw == FLAW_END_EARLY) begin
      cut = $urandom_range(1, line.size() - 1);
      for (int i = 0; i < cut; i++) send_item(line[i], 1'b0);
      if (flaw == FLAW_END_EARLY) send_end();
      else begin
        do c = 8'($urandom_range(0, 255)); while (hex_digit_value(c) < 16);
        send_item(c, 1'b0);
      end
      return;
    end
    foreach (line[i]) send_item(line[i], 1'b0);
    if (flaw == FLAW_CKSUM) return;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 2))
        0: send_item(CH_TAB, 1'b0);
        1: send_item(CH_CR, 1'b0);
        default: send_item(CH_SPACE, 1'b0);
      endcase
    end
    if (flaw == FLAW_TAIL_CHAR) begin
      do c = 8'($urandom_range(0, 255));
      while (c == CH_TAB || c == CH_CR || c == CH_SPACE || c == CH_LF);
      send_item(c, 1'b0);
    end else if (flaw == FLAW_END_AFTER_SUM) send_end();
    else send_item(CH_LF, 1'b0);
  endtask

  task automatic send_random_stream(input int item_goal);
    int pick;
    logic [7:0] len;
    logic [15:0] addr;
    logic [7:0] rtype;
    rec_flaw_t flaw;
    while (n_items < item_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) send_item(8'($urandom_range(0, 255)), 1'b0);
      else if (pick < 8) send_end();
      else begin
        len = ($urandom_range(0, 99) < 2) ? 8'($urandom_range(9, 64))
                                          : 8'($urandom_range(0, 8));
        case ($urandom_range(0, 5))
          0: addr = 16'h0000;
          1: addr = 16'hFFFF;
          default: addr = 16'($urandom_range(0, 65535));
        endcase
        pick = $urandom_range(0, 3);
        if (pick == 0) rtype = trk.eof_type;
        else if (pick == 1) rtype = 8'($urandom_range(0, 255));
        else rtype = 8'($urandom_range(0, 5));
        pick = $urandom_range(0, 99);
        if (pick < 70) flaw = FLAW_NONE;
        else if (pick < 76) flaw = FLAW_CKSUM;
        else if (pick < 82) flaw = FLAW_NONHEX;
        else if (pick < 88) flaw = FLAW_END_EARLY;
        else if (pick < 94) flaw = FLAW_TAIL_CHAR;
        else flaw = FLAW_END_AFTER_SUM;
        send_record(len, addr, rtype, flaw);
      end
    end
  endtask

  // result side: random pop, with a long hold-off on request
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        hex_result_t got;
        got.kind = out_kind;
        got.data_byte = out_data_byte;
        got.offset = out_offset;
        got.addr = out_rec_addr;
        got.rtype = out_rec_type;
        got.len = out_rec_len;
        got.status = status_t'(out_status);
        trk.check_result(got);
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= steady || $urandom_range(0, 99) >= 35;
      end
    end
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    trk = new();
    n_items = 0;
    hold_left = 0;
    steady = 1'b0;
    rst_n = 1'b0;
    push = 1'b0;
    in_ch = '0;
    in_at_end = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_eof_type(8'h00);

    // stray character, end while hunting, end and bad digit inside a record
    send_text("Z");
    send_item(CH_LF, 1'b0);
    send_end();
    send_text(":1");
    send_end();
    send_text(":0g");
    // zero length end-of-file record closed by end of file
    send_text(":00FFFF0002");
    send_end();
    send_text(":01000000ff00");
    send_item(CH_LF, 1'b0);

    // receiver stalls while characters keep coming
    hold_left = HOLD_CYCLES;
    send_random_stream(n_items + 500);

    write_eof_type(8'hFF);
    steady = 1'b1;
    send_random_stream(n_items + 400);
    steady = 1'b0;

    write_eof_type(8'($urandom_range(0, 255)));
    send_record(8'd255, 16'($urandom_range(0, 65535)), 8'h00, FLAW_NONE);
    send_random_stream(ITEM_GOAL);

    write_eof_type(EOF_TYPE_RST);
    send_random_stream(ITEM_GOAL + 100);

    push <= 1'b0;
    @(posedge clk);
    while (trk.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (trk.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
